// ===== src/cabl_pkg.sv =====
// Shared constants, types and state codes of the channel airtime budget ledger.
package cabl_pkg;

	localparam int CHANNEL_COUNT = 8;
	localparam int RING_DEPTH    = 360;
	localparam int BUCKET_MS     = 10000;

	localparam int CH_W   = $clog2(CHANNEL_COUNT);
	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int ROW_W  = CHANNEL_COUNT * 16;

	localparam logic [31:0] BUCKET_MS_W  = 32'(BUCKET_MS);
	localparam logic [31:0] RING_DEPTH_W = 32'(RING_DEPTH);

	// Reciprocal constants for division by the bucket length and by the ring depth.
	// Bucket numbers never exceed QB_W bits, so the ring reciprocal only needs that range.
	localparam int BUCKET_SHIFT = 31 + $clog2(BUCKET_MS);
	localparam int QB_W         = $clog2(64'hFFFF_FFFF / 64'(BUCKET_MS) + 64'd1);
	localparam int RING_SHIFT   = QB_W + $clog2(RING_DEPTH);
	localparam logic [31:0] RECIP_BUCKET =
		32'(((64'd1 << BUCKET_SHIFT) + 64'(BUCKET_MS) - 64'd1) / 64'(BUCKET_MS));
	localparam logic [31:0] RECIP_RING =
		32'(((64'd1 << RING_SHIFT) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH));

	// Register byte addresses on the configuration port.
	localparam logic [3:0] ADDR_CAP    = 4'd0;
	localparam logic [3:0] ADDR_WINDOW = 4'd4;
	localparam logic [3:0] ADDR_GAP    = 4'd8;

	localparam logic [31:0] WINDOW_RESET = 32'd3600000;

	typedef enum logic [1:0] {
		KIND_RECORD   = 2'd0,
		KIND_POLL     = 2'd1,
		KIND_ASK      = 2'd2,
		KIND_DEADLINE = 2'd3
	} kind_t;

	typedef enum logic {
		DIV_BUCKET = 1'b0,
		DIV_RING   = 1'b1
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_DIVT,
		ST_AGE,
		ST_DIVR,
		ST_REC_RD,
		ST_REC_WR,
		ST_DIVW,
		ST_SUM,
		ST_FIN
	} state_t;

endpackage

// ===== src/cabl_if.sv =====
// Valid/ready channel interfaces for the ledger's input and result transactions.
interface cabl_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  channel;
	logic [15:0] duration_ms;
	logic [31:0] now_ms;

	modport source (output valid, kind, channel, duration_ms, now_ms, input ready);
	modport sink (input valid, kind, channel, duration_ms, now_ms, output ready);
endinterface

interface cabl_out_if;
	logic        valid;
	logic        ready;
	logic        beat_fired;
	logic        allowed;
	logic        budget_refused;
	logic [31:0] deadline_ms;
	logic        any_budget;

	modport source (output valid, beat_fired, allowed, budget_refused, deadline_ms, any_budget,
		input ready);
	modport sink (input valid, beat_fired, allowed, budget_refused, deadline_ms, any_budget,
		output ready);
endinterface

// ===== src/channel_airtime_budget_ledger.sv =====
// Top level of the per-channel airtime ledger with bucketed sliding window.
// One transaction is taken at a time. Asks, deadline queries, polls not due and bad-channel
// records go to the finish state. A valid record or a due poll first divides now_ms by the
// bucket length on a shared reciprocal-multiply divider, then ages the ring one bucket
// row per cycle (up to RING_DEPTH-1 rows); a jump of a whole ring or more clears all
// RING_DEPTH rows and runs one more division for the ring slot. A record then does a
// read-modify-write of its bucket. A recompute divides the window by the bucket length
// and sums one ring row per cycle over the window (up to RING_DEPTH rows), all channels
// in parallel. After reset the bucket memory is cleared one row per cycle, all RING_DEPTH
// rows, during which no transaction is accepted; configuration writes are taken at any time.
module channel_airtime_budget_ledger
	import cabl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	cabl_in_if.sink     in_ch,
	cabl_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// Configuration registers.
	logic [31:0] cap_q, win_q, gap_q;

	// Sequencer and item registers.
	state_t      state_q, state_d;
	logic [31:0] t_q;
	logic [CH_W-1:0] ch_q;
	logic [15:0] dur_q;
	logic        rec_q;

	// Ledger state.
	logic [31:0] cur_q;
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] clr_q;
	logic        clr_full_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SLOT_W-1:0] rsl_q;
	logic        rd_v_s1;
	logic [CHANNEL_COUNT-1:0] ok_q;
	logic [31:0] last_q [CHANNEL_COUNT];
	logic        armed_q;
	logic [31:0] due_q;
	logic [31:0] acc_q [CHANNEL_COUNT];

	// Result registers.
	logic        fired_q, allowed_q, refused_q;
	logic [31:0] dl_q;
	logic        out_v_q, out_fired_q, out_allowed_q, out_refused_q, out_any_q;
	logic [31:0] out_dl_q;

	// Bucket memory: one row per ring slot, one 16-bit lane per channel.
	logic [ROW_W-1:0] mem [RING_DEPTH];
	logic [ROW_W-1:0] rdata_q;
	logic             we, re;
	logic [SLOT_W-1:0] waddr, raddr;
	logic [ROW_W-1:0] wdata;

	// Divider hookup.
	logic        div_start, div_done, div_busy;
	div_sel_t    div_sel;
	logic [31:0] div_dvd, div_quot, div_rem;

	// Helpers.
	logic        accept, cfg_wr, ch_valid, due_now, post_go, sum_done, out_free;
	logic [31:0] due_diff, steps, limit, dl_diff, gap_diff;
	logic [CNT_W-1:0] span;
	logic [SLOT_W-1:0] slot_inc, rsl_dec;
	logic [16:0] sat_sum;
	logic        any_acc;
	logic [CH_W-1:0] in_ch_idx;

	cabl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.sel      (div_sel),
		.dividend (div_dvd),
		.done     (div_done),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		unique case (paddr)
			ADDR_CAP:    prdata = cap_q;
			ADDR_WINDOW: prdata = win_q;
			ADDR_GAP:    prdata = gap_q;
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= '0;
			win_q <= WINDOW_RESET;
			gap_q <= '0;
		end else if (cfg_wr) begin
			if (paddr == ADDR_CAP) cap_q <= pwdata;
			if (paddr == ADDR_WINDOW) win_q <= pwdata;
			if (paddr == ADDR_GAP) gap_q <= pwdata;
		end
	end

	// Handshake and per-item decisions taken at acceptance.
	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign in_ch_idx   = in_ch.channel[CH_W-1:0];
	assign ch_valid    = (in_ch.channel < 8'(CHANNEL_COUNT));
	assign due_diff    = in_ch.now_ms - due_q;
	assign due_now     = armed_q && !due_diff[31];
	assign dl_diff     = due_q - in_ch.now_ms;
	assign gap_diff    = in_ch.now_ms - last_q[in_ch_idx];

	// Ring arithmetic.
	assign steps    = div_quot - cur_q;
	assign slot_inc = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
	assign rsl_dec  = (rsl_q == '0) ? SLOT_W'(RING_DEPTH - 1) : rsl_q - SLOT_W'(1);
	assign span     = (div_quot >= RING_DEPTH_W) ? CNT_W'(RING_DEPTH) : div_quot[CNT_W-1:0];
	assign limit    = (cap_q > BUCKET_MS_W) ? cap_q - BUCKET_MS_W : '0;
	assign sat_sum  = {1'b0, rdata_q[ch_q*16 +: 16]} + {1'b0, dur_q};
	assign sum_done = (state_q == ST_SUM) && (cnt_q == '0) && !rd_v_s1;
	assign out_free = !out_v_q || out_ch.ready;

	assign post_go = ((state_q == ST_DIVT) && div_done && (steps == '0)) ||
		((state_q == ST_AGE) && (cnt_q == CNT_W'(1))) ||
		((state_q == ST_DIVR) && div_done);

	always_comb begin
		any_acc = 1'b0;
		for (int c = 1; c < CHANNEL_COUNT; c++) begin
			if (acc_q[c] != '0) any_acc = 1'b1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_q == SLOT_W'(RING_DEPTH - 1)) state_d = clr_full_q ? ST_DIVR : ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (((in_ch.kind == KIND_RECORD) && ch_valid) ||
						((in_ch.kind == KIND_POLL) && due_now)) state_d = ST_DIVT;
					else state_d = ST_FIN;
				end
			end
			ST_DIVT: begin
				if (div_done) begin
					if (steps >= RING_DEPTH_W) state_d = ST_CLR;
					else if (steps != '0) state_d = ST_AGE;
				end
			end
			ST_DIVW: begin
				if (div_done) state_d = (span == '0) ? ST_FIN : ST_SUM;
			end
			ST_REC_RD: state_d = ST_REC_WR;
			ST_REC_WR: state_d = ST_FIN;
			ST_SUM: begin
				if (sum_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: ;
		endcase
		// After aging a record updates its bucket; capped polls recompute verdicts.
		if (post_go) begin
			if (rec_q) state_d = ST_REC_RD;
			else if (cap_q == '0) state_d = ST_FIN;
			else state_d = ST_DIVW;
		end
	end

	// Memory port and divider controls.
	always_comb begin
		we        = 1'b0;
		waddr     = slot_q;
		wdata     = '0;
		re        = 1'b0;
		raddr     = slot_q;
		div_start = 1'b0;
		div_sel   = DIV_BUCKET;
		div_dvd   = win_q;
		unique case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
			end
			ST_AGE: begin
				we    = 1'b1;
				waddr = slot_inc;
			end
			ST_REC_RD: re = 1'b1;
			ST_REC_WR: begin
				we    = 1'b1;
				wdata = rdata_q;
				wdata[ch_q*16 +: 16] = sat_sum[16] ? 16'hFFFF : sat_sum[15:0];
			end
			ST_SUM: begin
				re    = (cnt_q != '0);
				raddr = rsl_q;
			end
			default: ;
		endcase
		if (state_d != state_q) begin
			unique case (state_d)
				ST_DIVT: begin
					div_start = 1'b1;
					div_dvd   = in_ch.now_ms;
				end
				ST_DIVR: begin
					div_start = 1'b1;
					div_sel   = DIV_RING;
					div_dvd   = cur_q;
				end
				ST_DIVW: div_start = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	// Item registers and ledger state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			clr_full_q <= 1'b0;
			cur_q      <= '0;
			slot_q     <= '0;
			cnt_q      <= '0;
			rsl_q      <= '0;
			rd_v_s1    <= 1'b0;
			ok_q       <= '1;
			armed_q    <= 1'b1;
			due_q      <= '0;
			rec_q      <= 1'b0;
			for (int c = 0; c < CHANNEL_COUNT; c++) last_q[c] <= '0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= re && (state_q == ST_SUM);

			if (state_q == ST_CLR) clr_q <= clr_q + SLOT_W'(1);

			if (accept) rec_q <= (in_ch.kind == KIND_RECORD);

			// Aging decision once the bucket number is known.
			if ((state_q == ST_DIVT) && div_done) begin
				cur_q <= div_quot;
				if (steps >= RING_DEPTH_W) begin
					clr_q      <= '0;
					clr_full_q <= 1'b1;
				end else begin
					cnt_q <= steps[CNT_W-1:0];
				end
			end
			if (state_q == ST_AGE) begin
				slot_q <= slot_inc;
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			if ((state_q == ST_DIVR) && div_done) begin
				slot_q     <= div_rem[SLOT_W-1:0];
				clr_full_q <= 1'b0;
			end

			// Recompute entry: rearm the due time and handle the uncapped case.
			if (post_go && !rec_q) begin
				due_q <= t_q + BUCKET_MS_W;
				if (cap_q == '0) begin
					ok_q    <= '1;
					armed_q <= 1'b0;
				end else begin
					ok_q[0] <= 1'b1;
				end
			end

			// Record: stamp the transmit and rearm a parked beat.
			if (state_q == ST_REC_WR) begin
				last_q[ch_q] <= t_q;
				if (!armed_q && (ch_q != '0)) begin
					armed_q <= 1'b1;
					due_q   <= t_q + BUCKET_MS_W;
				end
			end

			// Window length known: start the walk or settle an empty window.
			if ((state_q == ST_DIVW) && div_done) begin
				if (span == '0) begin
					for (int c = 1; c < CHANNEL_COUNT; c++) ok_q[c] <= (limit != '0);
					armed_q <= 1'b0;
				end else begin
					cnt_q <= span;
					rsl_q <= slot_q;
				end
			end

			if (re && (state_q == ST_SUM)) begin
				rsl_q <= rsl_dec;
				cnt_q <= cnt_q - CNT_W'(1);
			end

			if (sum_done) begin
				for (int c = 1; c < CHANNEL_COUNT; c++) ok_q[c] <= (acc_q[c] < limit);
				if (!any_acc) armed_q <= 1'b0;
			end
		end
	end

	// Window sums, one ring row per cycle across all channels.
	always_ff @(posedge clk) begin
		if ((state_q == ST_DIVW) && div_done) begin
			for (int c = 0; c < CHANNEL_COUNT; c++) acc_q[c] <= '0;
		end else if (rd_v_s1) begin
			for (int c = 0; c < CHANNEL_COUNT; c++) begin
				acc_q[c] <= acc_q[c] + {16'd0, rdata_q[c*16 +: 16]};
			end
		end
	end

	// Item payload and the answers that depend only on the state at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q       <= in_ch.now_ms;
			ch_q      <= in_ch_idx;
			dur_q     <= in_ch.duration_ms;
			fired_q   <= (in_ch.kind == KIND_POLL) && due_now;
			allowed_q <= (in_ch.kind == KIND_ASK) && ch_valid && ok_q[in_ch_idx] &&
				!((gap_q != '0) && (last_q[in_ch_idx] != '0) && (gap_diff < gap_q));
			refused_q <= (in_ch.kind == KIND_ASK) && ch_valid && !ok_q[in_ch_idx];
			if (in_ch.kind != KIND_DEADLINE) dl_q <= '0;
			else if (!armed_q) dl_q <= '1;
			else if ((dl_diff == '0) || dl_diff[31]) dl_q <= '0;
			else dl_q <= dl_diff;
		end
	end

	// Output register: holds one finished transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if ((state_q == ST_FIN) && out_free) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && out_free) begin
			out_fired_q   <= fired_q;
			out_allowed_q <= allowed_q;
			out_refused_q <= refused_q;
			out_dl_q      <= dl_q;
			out_any_q     <= |ok_q[CHANNEL_COUNT-1:1];
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.beat_fired     = out_fired_q;
	assign out_ch.allowed        = out_allowed_q;
	assign out_ch.budget_refused = out_refused_q;
	assign out_ch.deadline_ms    = out_dl_q;
	assign out_ch.any_budget     = out_any_q;

	// The ring slot always names a real row.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q < SLOT_W'(RING_DEPTH - 1) || slot_q == SLOT_W'(RING_DEPTH - 1))
		else $error("ring slot out of range");

	// The hailing channel is never out of budget.
	a_hail_ok: assert property (@(posedge clk) disable iff (!arst_n) ok_q[0])
		else $error("hailing channel marked out of budget");

	// An accepted transaction closes the input until its work is done.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("input taken while an item is in progress");

	// The shared divider is never restarted while busy.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

// ===== src/cabl_div.sv =====
// Shared divider by the bucket length or the ring depth, by reciprocal multiplication.
module cabl_div
	import cabl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  div_sel_t    sel,
	input  logic [31:0] dividend,
	output logic        done,
	output logic        busy,
	output logic [31:0] quot,
	output logic [31:0] rem
);

	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	div_sel_t    sel_q;
	logic [31:0] dvd_q;
	logic [63:0] prod_q;
	logic [31:0] quot_q;
	logic [31:0] rem_q;
	logic [31:0] recip;
	logic [31:0] dsr;
	logic [31:0] back;

	// Constants of the selected divisor.
	assign recip = (sel_q == DIV_RING) ? RECIP_RING : RECIP_BUCKET;
	assign dsr   = (sel_q == DIV_RING) ? RING_DEPTH_W : BUCKET_MS_W;
	assign back  = quot_q * dsr;

	// Three steps: multiply by the reciprocal, shift out the quotient, form the remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (step_q == 2'd2);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd2) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			sel_q <= sel;
		end else if (busy_q) begin
			case (step_q)
				2'd0: prod_q <= 64'(dvd_q) * 64'(recip);
				2'd1: quot_q <= (sel_q == DIV_RING) ? 32'(prod_q >> RING_SHIFT) :
					32'(prod_q >> BUCKET_SHIFT);
				default: rem_q <= dvd_q - back;
			endcase
		end
	end

	assign done = done_q;
	assign busy = busy_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule
